// ----- design/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_BITS     = 32;
    localparam int MUL_LAT       = 3;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } t_op;

    // Control that rides along with each beat through the cell chain
    typedef struct packed {
        logic vld;
        t_op  op;
        logic cmp;
        logic dz;
        logic neg;
    } t_ctl;

endpackage

`default_nettype wire

// ----- design/fpa_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpa_mul #(
    parameter int W = fpa_pkg::WORD_BITS,
    parameter int F = fpa_pkg::FRACTION_BITS
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_ma,
    input  wire logic [W-1:0] i_mb,
    input  wire logic         i_neg,
    output logic      [W-1:0] o_res
);

    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H + F;

    logic [2*H-1:0] w_pa;
    logic [2*H-1:0] w_pb;
    logic [2*H-1:0] r_ll, r_lh, r_hl, r_hh;
    logic           r_neg1, r_neg2;
    logic [4*H-1:0] r_prod;
    logic [PW-1:0]  w_sgn;

    assign w_pa = (2*H)'(i_ma);
    assign w_pb = (2*H)'(i_mb);

    // partial products, one register level
    always_ff @(posedge i_clk) begin
        r_ll   <= w_pa[H-1:0]   * w_pb[H-1:0];
        r_lh   <= w_pa[H-1:0]   * w_pb[2*H-1:H];
        r_hl   <= w_pa[2*H-1:H] * w_pb[H-1:0];
        r_hh   <= w_pa[2*H-1:H] * w_pb[2*H-1:H];
        r_neg1 <= i_neg;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (4*H)'(r_ll) + ((4*H)'(r_lh) << H) + ((4*H)'(r_hl) << H)
                + ((4*H)'(r_hh) << (2*H));
        r_neg2 <= r_neg1;
    end

    // apply sign, drop the fraction bits
    assign w_sgn = r_neg2 ? (PW'(0) - PW'(r_prod)) : PW'(r_prod);

    always_ff @(posedge i_clk) begin
        o_res <= w_sgn[F +: W];
    end

endmodule

`default_nettype wire

// ----- design/fpa_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpa_div_cell #(
    parameter int W = fpa_pkg::WORD_BITS,
    parameter int N = fpa_pkg::WORD_BITS + fpa_pkg::FRACTION_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire fpa_pkg::t_ctl i_ctl,
    input  wire logic [W-1:0] i_res,
    input  wire logic [N-1:0] i_dvd,
    input  wire logic [W-1:0] i_dsr,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_quo,
    input  wire logic         i_ld,
    input  wire logic [W-1:0] i_ld_res,
    output fpa_pkg::t_ctl     o_ctl,
    output logic      [W-1:0] o_res,
    output logic      [N-1:0] o_dvd,
    output logic      [W-1:0] o_dsr,
    output logic      [W-1:0] o_rem,
    output logic      [W-1:0] o_quo
);

    logic [W:0] w_trial;
    logic [W:0] w_diff;
    logic       w_ge;

    // one restoring step: bring down the next dividend bit
    assign w_trial = {i_rem, i_dvd[N-1]};
    assign w_diff  = w_trial - {1'b0, i_dsr};
    assign w_ge    = (w_trial >= {1'b0, i_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= i_ld ? i_ld_res : i_res;
        o_dvd <= {i_dvd[N-2:0], 1'b0};
        o_dsr <= i_dsr;
        o_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        o_quo <= {i_quo[W-2:0], w_ge};
    end

endmodule

`default_nettype wire

// ----- design/fixed_point_alu.sv -----
// Channel   Ports                                              Handshake
// --------  -------------------------------------------------  ---------------------------
// command   i_operation, i_operand_a, i_operand_b              beat when i_start && !o_busy
// result    o_result_value, o_compare_true, o_divide_by_zero   beat when o_strobe
//
// Every operation passes through the same chain of stages; one beat is taken every
// cycle, so o_busy stays low.
// The divider chain has one cell per quotient bit.
// The multiplier (three stages) joins the chain part way down.
// Reset (i_rst_n low, synchronous) drops every beat in flight.
// The receiver cannot stall: each result is on the ports for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS,
    parameter int WORD_BITS     = fpa_pkg::WORD_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic        [3:0]  i_operation,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_strobe,
    output logic signed      [31:0] o_result_value,
    output logic                    o_compare_true,
    output logic                    o_divide_by_zero
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int N   = W + F;
    localparam int LAT = N + 3;

    // Input stage: wrap operands to the word width
    logic                r_vld0;
    fpa_pkg::t_op        r_op0;
    logic signed [W-1:0] r_a0;
    logic signed [W-1:0] r_b0;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op0 <= fpa_pkg::t_op'(i_operation);
        r_a0  <= W'(i_operand_a);
        r_b0  <= W'(i_operand_b);
    end

    // Decode stage: simple operations, compare flag, magnitudes for mul/div
    fpa_pkg::t_ctl       n_ctl1;
    logic signed [W-1:0] n_res1;
    logic                w_lt, w_gt, w_eq;
    logic        [W-1:0] w_ma, w_mb;

    assign w_lt = r_a0 < r_b0;
    assign w_gt = r_b0 < r_a0;
    assign w_eq = r_a0 == r_b0;
    assign w_ma = r_a0[W-1] ? W'(-r_a0) : r_a0;
    assign w_mb = r_b0[W-1] ? W'(-r_b0) : r_b0;

    always_comb begin
        n_ctl1     = '0;
        n_ctl1.vld = r_vld0;
        n_ctl1.op  = r_op0;
        n_ctl1.neg = r_a0[W-1] ^ r_b0[W-1];
        n_ctl1.dz  = (r_op0 == fpa_pkg::OP_DIV) && (r_b0 == '0);
        n_res1     = '0;
        case (r_op0)
            fpa_pkg::OP_ADD:  n_res1 = r_a0 + r_b0;
            fpa_pkg::OP_SUB:  n_res1 = r_a0 - r_b0;
            fpa_pkg::OP_GT:   n_ctl1.cmp = w_gt;
            fpa_pkg::OP_LT:   n_ctl1.cmp = w_lt;
            fpa_pkg::OP_GE:   n_ctl1.cmp = !w_lt;
            fpa_pkg::OP_LE:   n_ctl1.cmp = !w_gt;
            fpa_pkg::OP_EQ:   n_ctl1.cmp = w_eq;
            fpa_pkg::OP_NE:   n_ctl1.cmp = !w_eq;
            fpa_pkg::OP_MIN:  n_res1 = w_lt ? r_a0 : r_b0;
            fpa_pkg::OP_MAX:  n_res1 = w_gt ? r_a0 : r_b0;
            fpa_pkg::OP_INC:  n_res1 = r_a0 + W'(1);
            fpa_pkg::OP_DEC:  n_res1 = r_a0 - W'(1);
            fpa_pkg::OP_FINT: n_res1 = r_a0 <<< F;
            fpa_pkg::OP_TINT: n_res1 = r_a0 >>> F;
            default:          n_res1 = '0;
        endcase
    end

    fpa_pkg::t_ctl r_ctl1;
    logic [W-1:0]  r_res1;
    logic [W-1:0]  r_ma1;
    logic [W-1:0]  r_mb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res1 <= n_res1;
        r_ma1  <= w_ma;
        r_mb1  <= w_mb;
    end

    // Multiplier: result lands at cell MUL_LAT of the chain
    logic [W-1:0] w_mul;

    fpa_mul #(
        .W (W),
        .F (F)
    ) u_mul (
        .i_clk (i_clk),
        .i_ma  (r_ma1),
        .i_mb  (r_mb1),
        .i_neg (r_ctl1.neg),
        .o_res (w_mul)
    );

    // Divider chain: one quotient bit per cell; every beat rides through it
    fpa_pkg::t_ctl c_ctl [N+1];
    logic [W-1:0]  c_res [N+1];
    logic [N-1:0]  c_dvd [N+1];
    logic [W-1:0]  c_dsr [N+1];
    logic [W-1:0]  c_rem [N+1];
    logic [W-1:0]  c_quo [N+1];

    assign c_ctl[0] = r_ctl1;
    assign c_res[0] = r_res1;
    assign c_dvd[0] = {r_ma1, F'(0)};
    assign c_dsr[0] = r_mb1;
    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic w_ld;
        assign w_ld = (k == fpa_pkg::MUL_LAT) && (c_ctl[k].op == fpa_pkg::OP_MUL);

        fpa_div_cell #(
            .W (W),
            .N (N)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (c_ctl[k]),
            .i_res    (c_res[k]),
            .i_dvd    (c_dvd[k]),
            .i_dsr    (c_dsr[k]),
            .i_rem    (c_rem[k]),
            .i_quo    (c_quo[k]),
            .i_ld     (w_ld),
            .i_ld_res (w_mul),
            .o_ctl    (c_ctl[k+1]),
            .o_res    (c_res[k+1]),
            .o_dvd    (c_dvd[k+1]),
            .o_dsr    (c_dsr[k+1]),
            .o_rem    (c_rem[k+1]),
            .o_quo    (c_quo[k+1])
        );
    end

    // Output stage: sign the quotient, pick the result, drive the beat
    fpa_pkg::t_ctl       w_end;
    logic signed [W-1:0] n_res;
    logic [W-1:0]        w_q;

    assign w_end = c_ctl[N];
    assign w_q   = w_end.neg ? W'(-c_quo[N]) : c_quo[N];

    always_comb begin
        n_res = c_res[N];
        if (w_end.op == fpa_pkg::OP_DIV) begin
            n_res = w_end.dz ? '0 : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_value   <= 32'(n_res);
        o_compare_true   <= w_end.cmp;
        o_divide_by_zero <= w_end.dz;
    end

    // Checks
    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_start && !o_busy, LAT) && $past(i_rst_n, LAT) |-> o_strobe)
        else $error("accepted beat did not come out after the fixed latency");

    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_divide_by_zero |-> o_result_value == '0)
        else $error("divide by zero with a nonzero result");

    a_dz_cmp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_divide_by_zero && o_compare_true))
        else $error("divide by zero and compare flag both set");

    a_cmp_res : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_compare_true |-> o_result_value == '0)
        else $error("comparison with a nonzero result");

endmodule

`default_nettype wire
